/* hdl/indexed_multi_list_manager_assert.svh */
// Assertion macros for the list manager checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef INDEXED_MULTI_LIST_MANAGER_ASSERT_SVH
`define INDEXED_MULTI_LIST_MANAGER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/imlm_pkg.sv */
`default_nettype none
package imlm_pkg;

  localparam int FUNC_W = 2;
  localparam int SEL_W  = 2;
  localparam int IDX_W  = 6;
  localparam int LINK_W = 7;

  localparam logic [LINK_W-1:0] END_MARK = 7'h7F;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_ATTACH = 2'd0;
  localparam func_t FUNC_DETACH = 2'd1;
  localparam func_t FUNC_WALK   = 2'd2;

  typedef logic [LINK_W-1:0] link_t;

endpackage
`default_nettype wire

/* hdl/imlm_ifs.sv */
`default_nettype none
interface imlm_in_if import imlm_pkg::*;;
  logic               valid;
  logic               ready;
  func_t              func;
  logic [SEL_W-1:0]   list_sel;
  logic [IDX_W-1:0]   entry_index;

  modport source (output valid, output func, output list_sel, output entry_index,
                  input ready);
  modport sink   (input valid, input func, input list_sel, input entry_index,
                  output ready);
endinterface

interface imlm_out_if import imlm_pkg::*;;
  logic               valid;
  logic               ready;
  logic               changed;
  logic [IDX_W-1:0]   member_index;
  logic               list_empty;
  logic               last;
  logic               all_empty;

  modport source (output valid, output changed, output member_index,
                  output list_empty, output last, output all_empty, input ready);
  modport sink   (input valid, input changed, input member_index,
                  input list_empty, input last, input all_empty, output ready);
endinterface
`default_nettype wire

/* hdl/imlm_link_mem.sv */
`default_nettype none
module imlm_link_mem import imlm_pkg::*; #(
  parameter int DEPTH  = 192,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire link_t             wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output link_t                  rdata
);

  link_t mem [DEPTH];
  link_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hdl/indexed_multi_list_manager.sv */
// channel  dir  handshake     payload
// in_ch    in   valid/ready   func, list_sel, entry_index
// out_ch   out  valid/ready   changed, member_index, list_empty, last, all_empty
//
// A changing attach steps S_ATT1, S_ATT2, S_RESP; a changing detach S_DET1, S_DET2, S_RESP;
// S_RESP loads the result. The split is set by the single write port of each link memory and
// its registered read. Walk: link read in S_WRD, result in S_WEMIT, per member; others S_RESP.
// Reset (rst_n low, synchronous) clears membership bits, heads and tails; links need none.
// One transaction is in work at a time; in_ch.ready is low until its last result is loaded.
// A stalled result holds in the output register and the sequencer waits behind it.
`default_nettype none
module indexed_multi_list_manager import imlm_pkg::*; #(
  parameter int ENTRY_COUNT = 64,
  parameter int LIST_COUNT  = 3
) (
  input wire logic   clk,
  input wire logic   rst_n,
  imlm_in_if.sink    in_ch,
  imlm_out_if.source out_ch
);

  localparam int SLOTS  = LIST_COUNT * ENTRY_COUNT;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int LSEL_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int CNT_W  = $clog2(ENTRY_COUNT);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ATT1  = 8'b0000_0010,
    S_ATT2  = 8'b0000_0100,
    S_DET1  = 8'b0000_1000,
    S_DET2  = 8'b0001_0000,
    S_WRD   = 8'b0010_0000,
    S_WEMIT = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  function automatic logic link_ok(link_t v);
    return v < LINK_W'(ENTRY_COUNT);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(logic [LSEL_W-1:0] s, link_t e);
    return ADDR_W'(int'(s) * ENTRY_COUNT + int'(e));
  endfunction

  state_t              state_r, state_nxt;
  logic [LSEL_W-1:0]   sidx_r, sidx_nxt;
  link_t               e_r, e_nxt;
  logic [ADDR_W-1:0]   me_r, me_nxt;
  link_t               cur_r, cur_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                changed_r, changed_nxt;
  logic                empty_r, empty_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_changed_r, out_changed_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_all_r, out_all_nxt;

  logic                member_r [SLOTS];
  link_t               heads_r [LIST_COUNT];
  link_t               tails_r [LIST_COUNT];

  logic                n_we, n_re, p_we, p_re;
  logic [ADDR_W-1:0]   n_waddr, n_raddr, p_waddr, p_raddr;
  link_t               n_wdata, p_wdata, n_rdata, p_rdata;

  logic                head_we, tail_we, mem_set, mem_clr;
  link_t               head_wdata, tail_wdata;

  logic                in_acc, can_load, all_empty;
  logic [LSEL_W+SEL_W-1:0] sel_ext;
  logic [LSEL_W-1:0]   sidx_in;
  logic                sel_ok_in, ok_in, member_in;
  link_t               e_in, cur_in, tail_cur, nx, pv, nx_s, pv_s;
  logic [ADDR_W-1:0]   me_in;
  logic                tail_ok, fin;

  imlm_link_mem #(.DEPTH(SLOTS), .ADDR_W(ADDR_W)) u_next (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(n_re), .raddr(n_raddr), .rdata(n_rdata)
  );

  imlm_link_mem #(.DEPTH(SLOTS), .ADDR_W(ADDR_W)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  always_comb begin
    all_empty = 1'b1;
    for (int i = 0; i < LIST_COUNT; i++) begin
      if (link_ok(heads_r[i])) begin
        all_empty = 1'b0;
      end
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign can_load    = !out_valid_r || out_ch.ready;

  assign sel_ext   = {{LSEL_W{1'b0}}, in_ch.list_sel};
  assign sidx_in   = sel_ext[LSEL_W-1:0];
  assign sel_ok_in = int'(in_ch.list_sel) < LIST_COUNT;
  assign e_in      = {1'b0, in_ch.entry_index};
  assign ok_in     = sel_ok_in && link_ok(e_in);
  assign me_in     = slot_of(sidx_in, e_in);
  assign member_in = ok_in ? member_r[me_in] : 1'b0;
  assign cur_in    = sel_ok_in ? heads_r[sidx_in] : END_MARK;

  assign tail_cur = tails_r[sidx_r];
  assign tail_ok  = link_ok(tail_cur);
  assign nx       = n_rdata;
  assign pv       = p_rdata;
  assign nx_s     = link_ok(nx) ? nx : END_MARK;
  assign pv_s     = link_ok(pv) ? pv : END_MARK;
  assign fin      = !link_ok(nx) || (cnt_r == CNT_W'(ENTRY_COUNT - 1));

  always_comb begin
    state_nxt       = state_r;
    sidx_nxt        = sidx_r;
    e_nxt           = e_r;
    me_nxt          = me_r;
    cur_nxt         = cur_r;
    cnt_nxt         = cnt_r;
    changed_nxt     = changed_r;
    empty_nxt       = empty_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_changed_nxt = out_changed_r;
    out_idx_nxt     = out_idx_r;
    out_empty_nxt   = out_empty_r;
    out_last_nxt    = out_last_r;
    out_all_nxt     = out_all_r;
    n_we = 1'b0; n_waddr = me_r; n_wdata = END_MARK;
    p_we = 1'b0; p_waddr = me_r; p_wdata = END_MARK;
    n_re = 1'b0; n_raddr = me_r;
    p_re = 1'b0; p_raddr = me_r;
    head_we = 1'b0; head_wdata = END_MARK;
    tail_we = 1'b0; tail_wdata = END_MARK;
    mem_set = 1'b0; mem_clr = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sidx_nxt    = sidx_in;
          e_nxt       = e_in;
          me_nxt      = me_in;
          changed_nxt = 1'b0;
          empty_nxt   = 1'b0;
          cnt_nxt     = '0;
          cur_nxt     = cur_in;
          state_nxt   = S_RESP;
          case (in_ch.func)
            FUNC_ATTACH: begin
              if (ok_in && !member_in) begin
                state_nxt = S_ATT1;
              end
            end
            FUNC_DETACH: begin
              if (member_in) begin
                state_nxt = S_DET1;
              end
            end
            FUNC_WALK: begin
              if (link_ok(cur_in)) begin
                state_nxt = S_WRD;
              end else begin
                empty_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_ATT1: begin
        n_we      = tail_ok;
        n_waddr   = slot_of(sidx_r, tail_cur);
        n_wdata   = e_r;
        p_we      = 1'b1;
        p_waddr   = me_r;
        p_wdata   = tail_ok ? tail_cur : END_MARK;
        state_nxt = S_ATT2;
      end
      S_ATT2: begin
        n_we        = 1'b1;
        n_waddr     = me_r;
        n_wdata     = END_MARK;
        tail_we     = 1'b1;
        tail_wdata  = e_r;
        head_we     = !tail_ok;
        head_wdata  = e_r;
        mem_set     = 1'b1;
        changed_nxt = 1'b1;
        state_nxt   = S_RESP;
      end
      S_DET1: begin
        n_re      = 1'b1;
        n_raddr   = me_r;
        p_re      = 1'b1;
        p_raddr   = me_r;
        state_nxt = S_DET2;
      end
      S_DET2: begin
        p_we        = link_ok(nx_s);
        p_waddr     = slot_of(sidx_r, nx_s);
        p_wdata     = pv_s;
        tail_we     = !link_ok(nx_s);
        tail_wdata  = pv_s;
        n_we        = link_ok(pv_s);
        n_waddr     = slot_of(sidx_r, pv_s);
        n_wdata     = nx_s;
        head_we     = !link_ok(pv_s);
        head_wdata  = nx_s;
        mem_clr     = 1'b1;
        changed_nxt = 1'b1;
        state_nxt   = S_RESP;
      end
      S_WRD: begin
        n_re      = 1'b1;
        n_raddr   = slot_of(sidx_r, cur_r);
        state_nxt = S_WEMIT;
      end
      S_WEMIT: begin
        if (can_load) begin
          out_valid_nxt   = 1'b1;
          out_changed_nxt = 1'b0;
          out_idx_nxt     = cur_r[IDX_W-1:0];
          out_empty_nxt   = 1'b0;
          out_last_nxt    = fin;
          out_all_nxt     = all_empty;
          cur_nxt         = nx;
          cnt_nxt         = cnt_r + 1'b1;
          state_nxt       = fin ? S_IDLE : S_WRD;
        end
      end
      S_RESP: begin
        if (can_load) begin
          out_valid_nxt   = 1'b1;
          out_changed_nxt = changed_r;
          out_idx_nxt     = '0;
          out_empty_nxt   = empty_r;
          out_last_nxt    = 1'b1;
          out_all_nxt     = all_empty;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        member_r[i] <= 1'b0;
      end
      for (int i = 0; i < LIST_COUNT; i++) begin
        heads_r[i] <= END_MARK;
        tails_r[i] <= END_MARK;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_set) begin
        member_r[me_r] <= 1'b1;
      end
      if (mem_clr) begin
        member_r[me_r] <= 1'b0;
      end
      if (head_we) begin
        heads_r[sidx_r] <= head_wdata;
      end
      if (tail_we) begin
        tails_r[sidx_r] <= tail_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    sidx_r        <= sidx_nxt;
    e_r           <= e_nxt;
    me_r          <= me_nxt;
    cur_r         <= cur_nxt;
    cnt_r         <= cnt_nxt;
    changed_r     <= changed_nxt;
    empty_r       <= empty_nxt;
    out_changed_r <= out_changed_nxt;
    out_idx_r     <= out_idx_nxt;
    out_empty_r   <= out_empty_nxt;
    out_last_r    <= out_last_nxt;
    out_all_r     <= out_all_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.changed      = out_changed_r;
  assign out_ch.member_index = out_idx_r;
  assign out_ch.list_empty   = out_empty_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.all_empty    = out_all_r;

endmodule
`default_nettype wire

/* hdl/imlm_checker.sv */
`default_nettype none
`include "indexed_multi_list_manager_assert.svh"
module imlm_checker import imlm_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_changed,
  input wire logic [IDX_W-1:0] out_member_index,
  input wire logic             out_list_empty,
  input wire logic             out_last,
  input wire logic             out_all_empty
);

  `IMLM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_changed, out_member_index, out_list_empty, out_last, out_all_empty}), "stalled result changed")
  `IMLM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after an accepted transaction")
  `IMLM_ASSERT_NOW(a_empty_walk, out_valid && out_list_empty, out_last && !out_changed && out_member_index == '0, "empty walk result malformed")
  `IMLM_ASSERT_NOW(a_changed_single, out_valid && out_changed, out_last && !out_list_empty && out_member_index == '0, "changed result malformed")

endmodule

bind indexed_multi_list_manager imlm_checker u_imlm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_changed      (out_ch.changed),
  .out_member_index (out_ch.member_index),
  .out_list_empty   (out_ch.list_empty),
  .out_last         (out_ch.last),
  .out_all_empty    (out_ch.all_empty)
);
`default_nettype wire
